/* hw/rtl/alc_pkg.sv */
// shared types and constants for the associative lookup cache
`timescale 1ns / 1ps

package alc_pkg;

    localparam int ENTRIES_DEF  = 8;
    localparam int KEY_BITS_DEF = 32;
    localparam int KEY_IN_BITS  = 32;
    localparam int VALUE_BITS   = 32;
    localparam int COUNT_BITS   = 32;

    typedef struct packed {
        logic [KEY_IN_BITS-1:0] lookup_key;
        logic [VALUE_BITS-1:0]  backing_value;
    } lookup_req_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] result_value;
        logic                  was_hit;
        logic                  was_found;
        logic [COUNT_BITS-1:0] lookups_total;
        logic [COUNT_BITS-1:0] hits_total;
    } lookup_rsp_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic capture;
        logic fill;
    } cell_ctrl_t;

endpackage

/* hw/rtl/assoc_lookup_cache.sv */
// top level of the fully associative lookup cache: sequencer, cell row, counters
//
//  channel | valid     | stall     | payload       | dir
//  --------+-----------+-----------+---------------+-----
//  request | req_valid | req_stall | req (key/val) | in
//  result  | rsp_valid | rsp_stall | rsp           | out
//
// one request at a time: the accept edge compares the key in every cell,
// the resolve step then finds hit and fill slot along the cell chain and writes
// the fill, which the compare of the following request must see
// a result waiting in the output register holds only the resolve step
// reset clears the valid bits and counters at once, no clearing pass

`timescale 1ns / 1ps

module assoc_lookup_cache
    import alc_pkg::*;
#(
    parameter int ENTRIES  = ENTRIES_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  lookup_req_t req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output lookup_rsp_t rsp
);

    typedef enum logic {
        ST_IDLE,
        ST_RESOLVE
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    lookup_rsp_t           rsp_reg;
    lookup_rsp_t           rsp_next;
    logic [COUNT_BITS-1:0] lookup_cnt_reg;
    logic [COUNT_BITS-1:0] lookup_cnt_next;
    logic [COUNT_BITS-1:0] hit_cnt_reg;
    logic [COUNT_BITS-1:0] hit_cnt_next;

    logic [KEY_BITS-1:0]   key_in;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] backing_reg;

    logic                  accept;
    logic                  commit;
    logic                  fill_go;
    logic                  any_hit;
    logic                  any_empty;
    logic [ENTRIES:0]      hit_chain;
    logic [ENTRIES:0]      empty_chain;
    logic [ENTRIES-1:0]    hit_sel;
    logic [ENTRIES-1:0]    empty_sel;
    logic [ENTRIES-1:0]    fill_sel;
    logic [VALUE_BITS-1:0] cell_value [ENTRIES];
    logic [VALUE_BITS-1:0] hit_value;
    logic [VALUE_BITS-1:0] result_value;
    cell_ctrl_t            ctrl [ENTRIES];

    generate
        if (KEY_BITS <= KEY_IN_BITS)
        begin : g_key_narrow
            assign key_in = req.lookup_key[KEY_BITS-1:0];
        end
        else
        begin : g_key_wide
            assign key_in = {{(KEY_BITS-KEY_IN_BITS){1'b0}}, req.lookup_key};
        end
    endgenerate

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid & ~req_stall;
    assign commit    = (state_reg == ST_RESOLVE) & (~rsp_valid_reg | ~rsp_stall);

    assign hit_chain[0]         = 1'b0;
    assign empty_chain[ENTRIES] = 1'b0;
    assign any_hit              = hit_chain[ENTRIES];
    assign any_empty            = empty_chain[0];
    assign fill_go              = commit & ~any_hit & (backing_reg != '0);

    generate
        for (genvar i = 0; i < ENTRIES; i++)
        begin : g_cell
            // slot 0 takes the fill when the cache is full
            if (i == 0)
            begin : g_first
                assign fill_sel[i] = empty_sel[i] | ~any_empty;
            end
            else
            begin : g_rest
                assign fill_sel[i] = empty_sel[i];
            end

            assign ctrl[i].capture = accept;
            assign ctrl[i].fill    = fill_go & fill_sel[i];

            alc_cell #(
                .KEY_BITS (KEY_BITS)
            ) u_cell (
                .clk            (clk),
                .rst_n          (rst_n),
                .ctrl           (ctrl[i]),
                .cmp_key        (key_in),
                .fill_key       (key_reg),
                .fill_value     (backing_reg),
                .hit_seen_in    (hit_chain[i]),
                .hit_seen_out   (hit_chain[i+1]),
                .empty_seen_in  (empty_chain[i+1]),
                .empty_seen_out (empty_chain[i]),
                .hit_sel        (hit_sel[i]),
                .empty_sel      (empty_sel[i]),
                .value_out      (cell_value[i])
            );
        end
    endgenerate

    always_comb
    begin
        hit_value = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_value = hit_value | cell_value[i];
        end
    end

    // a miss returns the backing value, which is zero when nothing is fetched
    assign result_value = any_hit ? hit_value : backing_reg;

    always_comb
    begin
        state_next      = state_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;
        lookup_cnt_next = lookup_cnt_reg;
        hit_cnt_next    = hit_cnt_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                if (commit)
                begin
                    lookup_cnt_next        = lookup_cnt_reg + COUNT_BITS'(1);
                    hit_cnt_next           = hit_cnt_reg + {{(COUNT_BITS-1){1'b0}}, any_hit};
                    rsp_next.result_value  = result_value;
                    rsp_next.was_hit       = any_hit;
                    rsp_next.was_found     = (result_value != '0);
                    rsp_next.lookups_total = lookup_cnt_next;
                    rsp_next.hits_total    = hit_cnt_next;
                    rsp_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
            lookup_cnt_reg <= '0;
            hit_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_reg        <= rsp_next;
            lookup_cnt_reg <= lookup_cnt_next;
            hit_cnt_reg    <= hit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg     <= key_in;
            backing_reg <= req.backing_value;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_sel))
        else $error("more than one cell selected as hit");

    a_fill_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        fill_go |-> $onehot(fill_sel))
        else $error("fill does not select exactly one cell");

    a_hit_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.was_hit |-> rsp.was_found)
        else $error("hit returned a zero value");

    a_commit_count: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> lookup_cnt_reg == $past(lookup_cnt_reg) + COUNT_BITS'(1))
        else $error("lookup counter did not advance on commit");

endmodule

/* hw/rtl/alc_cell.sv */
// one cache slot: key, value and valid bit with its compare and chain links
`timescale 1ns / 1ps

module alc_cell
    import alc_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cell_ctrl_t            ctrl,
    input  logic [KEY_BITS-1:0]   cmp_key,
    input  logic [KEY_BITS-1:0]   fill_key,
    input  logic [VALUE_BITS-1:0] fill_value,
    input  logic                  hit_seen_in,
    output logic                  hit_seen_out,
    input  logic                  empty_seen_in,
    output logic                  empty_seen_out,
    output logic                  hit_sel,
    output logic                  empty_sel,
    output logic [VALUE_BITS-1:0] value_out
);

    logic [KEY_BITS-1:0]   key_reg;
    logic [KEY_BITS-1:0]   key_next;
    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;
    logic                  valid_reg;
    logic                  valid_next;
    logic                  match_reg;
    logic                  match_next;

    always_comb
    begin
        match_next = ctrl.capture ? (valid_reg && (key_reg == cmp_key)) : match_reg;
        valid_next = valid_reg | ctrl.fill;
        key_next   = ctrl.fill ? fill_key : key_reg;
        value_next = ctrl.fill ? fill_value : value_reg;
    end

    // lowest matching slot wins, chain runs upwards
    assign hit_sel      = match_reg & ~hit_seen_in;
    assign hit_seen_out = hit_seen_in | match_reg;

    // highest empty slot wins, chain runs downwards
    assign empty_sel      = ~valid_reg & ~empty_seen_in;
    assign empty_seen_out = empty_seen_in | ~valid_reg;

    assign value_out = hit_sel ? value_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

endmodule
